### rtl/cgt_pkg.sv
package cgt_pkg;

    // Conversion direction carried in the action field
    localparam logic ACT_CAL_TO_GPS = 1'b0;
    localparam logic ACT_GPS_TO_CAL = 1'b1;

    // Time units in milliseconds
    localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;

    // Day-number offsets
    localparam logic [16:0] MJD_GPS_EPOCH = 17'd44244;    // MJD of 1980-01-06
    localparam logic [19:0] MJD_OFFSET    = 20'd679019;   // 2400000.5 - 1720981.5
    localparam logic [21:0] JD_B_OFFSET   = 22'd2401538;  // 2400001 + 1537
    localparam logic [11:0] JD_C_BIAS     = 12'd2442;     // 20 * 122.1
    localparam logic [12:0] JD_C_DIV      = 13'd7305;     // 20 * 365.25
    localparam logic [12:0] JD_YEAR_BASE  = 13'd4715;

    // Calendar limits and month codes
    localparam logic [11:0] YEAR_MIN    = 12'd1980;
    localparam logic [11:0] YEAR_MAX    = 12'd2099;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_SHIFT = 4'd12;  // Jan/Feb move to the prior year
    localparam logic [3:0]  E_WRAP      = 4'd14;  // first month index of the next year

    // Reciprocals for division by constants; each quotient comes out exact
    // or one short, and one compare-subtract stage fixes it up.
    // sow / 86400000 = (sow >> 10) / 84375
    localparam logic [10:0] DAY_RECIP   = 11'((32'd1 << 27) / 32'd84375);
    // exact for any 16-bit dividend, no fix-up needed
    localparam logic [16:0] WEEK7_RECIP = 17'(((33'd1 << 19) + 33'd6) / 33'd7);
    localparam logic [25:0] CAL_RECIP   = 26'((64'd1 << 38) / 64'd7305);
    // tod / 3600000 = (tod >> 7) / 28125
    localparam logic [10:0] HOUR_RECIP  = 11'((32'd1 << 25) / 32'd28125);
    // rem / 60000 = (rem >> 5) / 1875
    localparam logic [13:0] MIN_RECIP   = 14'((32'd1 << 24) / 32'd1875);

    typedef struct packed {
        logic        action;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] second_ms;
        logic [12:0] gps_week;
        logic [29:0] gps_sow_ms;
    } cmd_t;

    typedef struct packed {
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [15:0] out_second_ms;
        logic [12:0] out_gps_week;
        logic [29:0] out_gps_sow_ms;
        logic [16:0] mjd_days;
        logic [26:0] day_time_ms;
    } result_t;

    // Day number plus time of day handed from the front half to the back half
    typedef struct packed {
        logic        valid;
        logic [16:0] days;
        logic [26:0] tod_ms;
    } mjd_t;

    // floor(30.6001 * k)
    function automatic logic [8:0] month_span(input logic [4:0] k);
        logic [8:0] v;
        case (k)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // floor(x / 30.6001) for a day-of-year offset below 490
    function automatic logic [3:0] month_count(input logic [8:0] x);
        logic [22:0] xs;
        logic [3:0]  e;
        xs = 23'(x) * 23'd10000;
        e  = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (xs >= 23'(306001 * k))
            begin
                e = 4'(k);
            end
        end
        return e;
    endfunction

endpackage

### rtl/cgt_to_mjd.sv
module cgt_to_mjd (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cgt_pkg::cmd_t cmd,
    output cgt_pkg::mjd_t mjd
);

    // first stage: calendar day sum, raw time of day, day quotient estimate
    logic [11:0] year_sat;
    logic [11:0] year_adj;
    logic [4:0]  month_idx;
    logic [22:0] year_days;
    logic [21:0] days_sum;
    logic [26:0] tod_raw;
    logic [30:0] day_prod;

    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [16:0] s1_days_reg;
    logic [26:0] s1_tod_reg;
    logic [29:0] s1_sow_reg;
    logic [12:0] s1_week_reg;
    logic [3:0]  s1_qday_reg;

    // second stage: fix up the quotient, carry whole days, pick direction
    logic [27:0] sow_rem;
    logic [27:0] sow_fix;
    logic [3:0]  qday_fix;
    logic [16:0] days_gps;
    logic [16:0] days_cal;
    logic [26:0] tod_cal;

    cgt_pkg::mjd_t mjd_next;
    logic          mjd_valid_reg;
    logic [16:0]   mjd_days_reg;
    logic [26:0]   mjd_tod_reg;

    always_comb
    begin
        year_sat = cmd.year;
        if (cmd.year < cgt_pkg::YEAR_MIN)
        begin
            year_sat = cgt_pkg::YEAR_MIN;
        end
        if (cmd.year > cgt_pkg::YEAR_MAX)
        begin
            year_sat = cgt_pkg::YEAR_MAX;
        end
        // January and February count as months 13 and 14 of the year before
        if (cmd.month <= cgt_pkg::MONTH_FEB)
        begin
            year_adj  = year_sat - 12'd1;
            month_idx = 5'(cmd.month) + 5'(cgt_pkg::MONTH_SHIFT) + 5'd1;
        end
        else
        begin
            year_adj  = year_sat;
            month_idx = 5'(cmd.month) + 5'd1;
        end
        year_days = 23'(year_adj) * 23'd1461;
        days_sum  = 22'(year_days[22:2]) + 22'(cgt_pkg::month_span(month_idx))
                  + 22'(cmd.day) - 22'(cgt_pkg::MJD_OFFSET);
        tod_raw   = 27'(cmd.hour) * 27'(cgt_pkg::MS_PER_HOUR)
                  + 27'(cmd.minute) * 27'(cgt_pkg::MS_PER_MIN)
                  + 27'(cmd.second_ms);
        day_prod  = 31'(cmd.gps_sow_ms[29:10]) * 31'(cgt_pkg::DAY_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_action_reg <= cmd.action;
        s1_days_reg   <= days_sum[16:0];
        s1_tod_reg    <= tod_raw;
        s1_sow_reg    <= cmd.gps_sow_ms;
        s1_week_reg   <= cmd.gps_week;
        s1_qday_reg   <= day_prod[30:27];
    end

    always_comb
    begin
        sow_rem  = 28'(s1_sow_reg) - 28'(s1_qday_reg) * 28'(cgt_pkg::MS_PER_DAY);
        sow_fix  = sow_rem;
        qday_fix = s1_qday_reg;
        if (sow_rem >= 28'(cgt_pkg::MS_PER_DAY))
        begin
            sow_fix  = sow_rem - 28'(cgt_pkg::MS_PER_DAY);
            qday_fix = s1_qday_reg + 4'd1;
        end
        days_gps = cgt_pkg::MJD_GPS_EPOCH + 17'(s1_week_reg) * 17'd7 + 17'(qday_fix);

        // time of day stays under two days: carry at most one
        days_cal = s1_days_reg;
        tod_cal  = s1_tod_reg;
        if (s1_tod_reg >= cgt_pkg::MS_PER_DAY)
        begin
            days_cal = s1_days_reg + 17'd1;
            tod_cal  = s1_tod_reg - cgt_pkg::MS_PER_DAY;
        end

        mjd_next.valid = s1_valid_reg;
        if (s1_action_reg == cgt_pkg::ACT_GPS_TO_CAL)
        begin
            mjd_next.days   = days_gps;
            mjd_next.tod_ms = sow_fix[26:0];
        end
        else
        begin
            mjd_next.days   = days_cal;
            mjd_next.tod_ms = tod_cal;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mjd_valid_reg <= 1'b0;
        end
        else
        begin
            mjd_valid_reg <= mjd_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mjd_days_reg <= mjd_next.days;
        mjd_tod_reg  <= mjd_next.tod_ms;
    end

    assign mjd = {mjd_valid_reg, mjd_days_reg, mjd_tod_reg};

endmodule

### rtl/cgt_from_mjd.sv
module cgt_from_mjd (
    input  logic             clk,
    input  logic             rst_n,
    input  cgt_pkg::mjd_t    mjd,
    output logic             done,
    output cgt_pkg::result_t result
);

    // stage 3: quotient estimates for weeks, Julian years, hours
    logic [16:0] dsince;
    logic [32:0] w7_prod;
    logic [21:0] jd_b;
    logic [25:0] cnum;
    logic [51:0] cal_prod;
    logic [30:0] hr_prod;

    logic        s3_valid_reg;
    logic        s3_pre_reg;
    logic [15:0] s3_dweek_reg;
    logic [13:0] s3_q7_reg;
    logic [21:0] s3_b_reg;
    logic [25:0] s3_num_reg;
    logic [13:0] s3_cq_reg;
    logic [4:0]  s3_hq_reg;
    logic [16:0] s3_days_reg;
    logic [26:0] s3_tod_reg;

    // stage 4: GPS outputs, fix-ups of the estimates
    logic [15:0] rem7_wide;
    logic [2:0]  rem7;
    logic [25:0] c_rem;
    logic [13:0] c_fix;
    logic [22:0] hr_rem;
    logic [22:0] hr_fix;
    logic [4:0]  hour_fix;
    logic [12:0] gw_next;
    logic [29:0] gs_next;

    logic        s4_valid_reg;
    logic [12:0] s4_gw_reg;
    logic [29:0] s4_gs_reg;
    logic [12:0] s4_c_reg;
    logic [21:0] s4_b_reg;
    logic [4:0]  s4_hour_reg;
    logic [21:0] s4_hr_rem_reg;
    logic [16:0] s4_days_reg;
    logic [26:0] s4_tod_reg;

    // stage 5: day of year, minute estimate
    logic [23:0] cent_days;
    logic [21:0] doy_wide;
    logic [30:0] min_prod;

    logic        s5_valid_reg;
    logic [8:0]  s5_doy_reg;
    logic [12:0] s5_c_reg;
    logic [5:0]  s5_mq_reg;
    logic [21:0] s5_hr_rem_reg;
    logic [4:0]  s5_hour_reg;
    logic [12:0] s5_gw_reg;
    logic [29:0] s5_gs_reg;
    logic [16:0] s5_days_reg;
    logic [26:0] s5_tod_reg;

    // stage 6: month, day, year, minute and second
    logic [3:0]  e_idx;
    logic [8:0]  cday_wide;
    logic [3:0]  cmon;
    logic [12:0] cyear_wide;
    logic [16:0] min_rem;
    logic [16:0] min_fix;
    logic [5:0]  minute_fix;

    logic             done_reg;
    cgt_pkg::result_t result_next;
    cgt_pkg::result_t result_reg;

    always_comb
    begin
        dsince   = mjd.days - cgt_pkg::MJD_GPS_EPOCH;
        w7_prod  = 33'(dsince[15:0]) * 33'(cgt_pkg::WEEK7_RECIP);
        jd_b     = 22'(mjd.days) + cgt_pkg::JD_B_OFFSET;
        cnum     = 26'(jd_b) * 26'd20 - 26'(cgt_pkg::JD_C_BIAS);
        cal_prod = 52'(cnum) * 52'(cgt_pkg::CAL_RECIP);
        hr_prod  = 31'(mjd.tod_ms[26:7]) * 31'(cgt_pkg::HOUR_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= mjd.valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            done_reg     <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_pre_reg   <= (mjd.days < cgt_pkg::MJD_GPS_EPOCH);
        s3_dweek_reg <= dsince[15:0];
        s3_q7_reg    <= w7_prod[32:19];
        s3_b_reg     <= jd_b;
        s3_num_reg   <= cnum;
        s3_cq_reg    <= cal_prod[51:38];
        s3_hq_reg    <= hr_prod[29:25];
        s3_days_reg  <= mjd.days;
        s3_tod_reg   <= mjd.tod_ms;
    end

    always_comb
    begin
        // weeks and day of week since the epoch; zero before the epoch
        rem7_wide = s3_dweek_reg - 16'(s3_q7_reg) * 16'd7;
        rem7      = rem7_wide[2:0];
        if (s3_pre_reg)
        begin
            gw_next = '0;
            gs_next = '0;
        end
        else
        begin
            gw_next = s3_q7_reg[12:0];
            gs_next = 30'(rem7) * 30'(cgt_pkg::MS_PER_DAY) + 30'(s3_tod_reg);
        end

        c_rem = s3_num_reg - 26'(s3_cq_reg) * 26'(cgt_pkg::JD_C_DIV);
        c_fix = s3_cq_reg;
        if (c_rem >= 26'(cgt_pkg::JD_C_DIV))
        begin
            c_fix = s3_cq_reg + 14'd1;
        end

        hr_rem   = 23'(s3_tod_reg) - 23'(s3_hq_reg) * 23'(cgt_pkg::MS_PER_HOUR);
        hr_fix   = hr_rem;
        hour_fix = s3_hq_reg;
        if (hr_rem >= 23'(cgt_pkg::MS_PER_HOUR))
        begin
            hr_fix   = hr_rem - 23'(cgt_pkg::MS_PER_HOUR);
            hour_fix = s3_hq_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_gw_reg     <= gw_next;
        s4_gs_reg     <= gs_next;
        s4_c_reg      <= c_fix[12:0];
        s4_b_reg      <= s3_b_reg;
        s4_hour_reg   <= hour_fix;
        s4_hr_rem_reg <= hr_fix[21:0];
        s4_days_reg   <= s3_days_reg;
        s4_tod_reg    <= s3_tod_reg;
    end

    always_comb
    begin
        cent_days = 24'(s4_c_reg) * 24'd1461;
        doy_wide  = s4_b_reg - cent_days[23:2];
        min_prod  = 31'(s4_hr_rem_reg[21:5]) * 31'(cgt_pkg::MIN_RECIP);
    end

    always_ff @(posedge clk)
    begin
        s5_doy_reg    <= doy_wide[8:0];
        s5_c_reg      <= s4_c_reg;
        s5_mq_reg     <= min_prod[29:24];
        s5_hr_rem_reg <= s4_hr_rem_reg;
        s5_hour_reg   <= s4_hour_reg;
        s5_gw_reg     <= s4_gw_reg;
        s5_gs_reg     <= s4_gs_reg;
        s5_days_reg   <= s4_days_reg;
        s5_tod_reg    <= s4_tod_reg;
    end

    always_comb
    begin
        e_idx     = cgt_pkg::month_count(s5_doy_reg);
        cday_wide = s5_doy_reg - cgt_pkg::month_span(5'(e_idx));
        if (e_idx < cgt_pkg::E_WRAP)
        begin
            cmon = e_idx - 4'd1;
        end
        else
        begin
            cmon = e_idx - 4'd13;
        end
        // March onward belongs to the Julian year one below the count
        cyear_wide = s5_c_reg - cgt_pkg::JD_YEAR_BASE
                   - ((cmon >= cgt_pkg::MONTH_MAR) ? 13'd1 : 13'd0);

        min_rem    = 17'(s5_hr_rem_reg) - 17'(s5_mq_reg) * 17'(cgt_pkg::MS_PER_MIN);
        min_fix    = min_rem;
        minute_fix = s5_mq_reg;
        if (min_rem >= 17'(cgt_pkg::MS_PER_MIN))
        begin
            min_fix    = min_rem - 17'(cgt_pkg::MS_PER_MIN);
            minute_fix = s5_mq_reg + 6'd1;
        end

        result_next.out_year       = cyear_wide[11:0];
        result_next.out_month      = cmon;
        result_next.out_day        = cday_wide[4:0];
        result_next.out_hour       = s5_hour_reg;
        result_next.out_minute     = minute_fix;
        result_next.out_second_ms  = min_fix[15:0];
        result_next.out_gps_week   = s5_gw_reg;
        result_next.out_gps_sow_ms = s5_gs_reg;
        result_next.mjd_days       = s5_days_reg;
        result_next.day_time_ms    = s5_tod_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/calendar_gps_time_converter_core.sv
// An accepted item passes the input register, then the stages of cgt_to_mjd and cgt_from_mjd, before done rises.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// The pipeline has seven register stages; the widest one holds a 26 x 26 multiply.
// Reset (rst_n low, asynchronous) clears every stage's valid bit; data holds no reset.
// The receiver cannot stall: each result is shown for one cycle only.
module calendar_gps_time_converter_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cgt_pkg::cmd_t    cmd,
    output logic             done,
    output cgt_pkg::result_t result
);

    // Input register: capture the item on the accepting edge.
    logic          cmd_valid_reg;
    cgt_pkg::cmd_t cmd_reg;
    logic          accept;

    // Day number and time of day between the two halves.
    cgt_pkg::mjd_t mjd;

    // Every stage advances every cycle, so an item never waits.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // Front half: form the MJD day and time of day from either direction.
    cgt_to_mjd u_to_mjd (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid_reg),
        .cmd       (cmd_reg),
        .mjd       (mjd)
    );

    // Back half: derive GPS week, seconds of week and the calendar instant.
    cgt_from_mjd u_from_mjd (
        .clk    (clk),
        .rst_n  (rst_n),
        .mjd    (mjd),
        .done   (done),
        .result (result)
    );

    // A result strobe only ever follows an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 7))
        else $error("result strobe without a matching item");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_month >= 4'd1 && result.out_month <= 4'd12))
        else $error("month out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_hour <= 5'd23 && result.out_minute <= 6'd59
                  && result.out_second_ms < cgt_pkg::MS_PER_MIN))
        else $error("time of day split out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.day_time_ms < cgt_pkg::MS_PER_DAY
                  && result.out_gps_sow_ms < 30'd604800000))
        else $error("day or week remainder out of range");

endmodule
